// ===== sv/ppd_pkg.sv =====
// shared constants and result codes for the proximity point deduplicator
// no dependencies
package ppd_pkg;

   localparam int CAPACITY = 30;
   localparam int COORD_W  = 16;
   localparam int COUNT_W  = 8;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POINT_W  = 2 * COORD_W;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [COORD_W-1:0] RANGE_RESET = COORD_W'(50);

   localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CLOSE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

endpackage

// ===== sv/ppd_if.sv =====
// handshake interfaces for the hit channel and the result channel
// depends on ppd_pkg
interface ppd_req_if import ppd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] hit_x;
   logic [COORD_W-1:0] hit_y;

   modport source (output valid, hit_x, hit_y, input ready);
   modport sink (input valid, hit_x, hit_y, output ready);
endinterface

interface ppd_rsp_if import ppd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [COUNT_W-1:0]  point_count;

   modport source (output valid, status, slot, point_count, input ready);
   modport sink (input valid, status, slot, point_count, output ready);
endinterface

// ===== sv/ppd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ppd_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 30,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/proximity_point_deduplicator.sv =====
// proximity point deduplicator top level: scan sequencer, point table, csr port
// depends on ppd_pkg, ppd_if and ppd_ram
//
// usage:
//   req_if carries one hit (hit_x, hit_y) per transaction; rsp_if returns exactly
//   one result per hit (status, slot, point_count) in order.
//   status is stored, too close or table full; slot is the table index written
//   for a stored hit and zero otherwise; point_count is the count after the hit.
//   csr_ is an apb-style port with proximity_range at byte address 0; write it
//   only while no hit is in flight.
// timing:
//   a hit is compared against the stored points one per cycle, reading the point
//   table ram; an empty or full table skips the scan. a new hit is taken only
//   after the last result has left S_EMIT for the output register. at the end of
//   the scan the result is registered in S_EMIT, then moved to the output register.
// reset:
//   synchronous, clears the point count and the handshake state and sets
//   proximity_range to 50; the table ram is not cleared, entries are only used
//   below the count.
// stall:
//   the result sits in an output register, so the next hit is accepted while it
//   waits; a second finished result waits in the block until rsp_if.ready.
module proximity_point_deduplicator import ppd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ppd_req_if.sink           req_if,
   ppd_rsp_if.source         rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                close_ff, close_in;
   logic [COORD_W-1:0]  hx_ff, hx_in;
   logic [COORD_W-1:0]  hy_ff, hy_in;
   logic [COORD_W-1:0]  range_ff, range_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                csr_wr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [POINT_W-1:0]  wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [POINT_W-1:0]  rd_data;
   logic [COORD_W-1:0]  px, py, dx, dy;
   logic                hit_close;
   logic                scan_last;
   logic                out_free;

   ppd_ram #(
      .WIDTH (POINT_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DW'(range_ff);

   // per-axis distance against the entry read last cycle
   assign px        = rd_data[POINT_W-1:COORD_W];
   assign py        = rd_data[COORD_W-1:0];
   assign dx        = (px >= hx_ff) ? (px - hx_ff) : (hx_ff - px);
   assign dy        = (py >= hy_ff) ? (py - hy_ff) : (hy_ff - py);
   assign hit_close = (dx < range_ff) && (dy < range_ff);
   assign scan_last = (COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff;

   assign rd_addr = (state_ff == S_SCAN) ? (idx_ff + ADDR_W'(1)) : ADDR_W'(0);
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = (state_ff == S_IDLE) ? {req_if.hit_x, req_if.hit_y}
                                         : {hx_ff, hy_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      close_in      = close_ff;
      hx_in         = hx_ff;
      hy_in         = hy_ff;
      range_in      = csr_wr ? csr_pwdata[COORD_W-1:0] : range_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hx_in    = req_if.hit_x;
               hy_in    = req_if.hit_y;
               idx_in   = '0;
               close_in = 1'b0;
               if (count_ff >= CAPACITY_COUNT) begin
                  res_status_in = ST_FULL;
                  res_slot_in   = '0;
                  res_count_in  = count_ff;
                  state_in      = S_EMIT;
               end else if (count_ff == '0) begin
                  wr_en         = 1'b1;
                  res_status_in = ST_STORED;
                  res_slot_in   = SLOT_W'(count_ff);
                  res_count_in  = count_ff + COUNT_W'(1);
                  count_in      = count_ff + COUNT_W'(1);
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            close_in = close_ff || hit_close;
            idx_in   = idx_ff + ADDR_W'(1);
            if (scan_last) begin
               state_in = S_EMIT;
               if (close_ff || hit_close) begin
                  res_status_in = ST_CLOSE;
                  res_slot_in   = '0;
                  res_count_in  = count_ff;
               end else begin
                  wr_en         = 1'b1;
                  res_status_in = ST_STORED;
                  res_slot_in   = SLOT_W'(count_ff);
                  res_count_in  = count_ff + COUNT_W'(1);
                  count_in      = count_ff + COUNT_W'(1);
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = res_count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         range_ff     <= RANGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      close_ff      <= close_in;
      hx_ff         <= hx_in;
      hy_ff         <= hy_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.slot        = rsp_slot_ff;
   assign rsp_if.point_count = rsp_count_ff;

endmodule

// ===== sv/ppd_checker.sv =====
// port-level checks on the result channel of the deduplicator
// depends on ppd_pkg; bound to proximity_point_deduplicator
module ppd_checker import ppd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic [COUNT_W-1:0]  rsp_point_count
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_STORED || rsp_status == ST_CLOSE ||
                     rsp_status == ST_FULL))
      else $error("unknown status code");

   a_stored_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STORED |->
         COUNT_W'(rsp_slot) + COUNT_W'(1) == rsp_point_count)
      else $error("stored slot does not match count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_point_count == CAPACITY_COUNT && rsp_slot == '0)
      else $error("full result with wrong count or slot");

endmodule

bind proximity_point_deduplicator ppd_checker u_ppd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_slot        (rsp_if.slot),
   .rsp_point_count (rsp_if.point_count)
);

// ===== tb/sv/proximity_point_deduplicator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for proximity_point_deduplicator: directed and random hits,
// range register writes between phases, results checked against an in-bench table model
// depends on ppd_pkg, ppd_if and the proximity_point_deduplicator rtl
module proximity_point_deduplicator_tb import ppd_pkg::*; ();

   localparam int PHASES       = 32;
   localparam int PHASE_HITS   = 50;
   localparam int FILL_PHASES  = 26;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 40;

   localparam logic [CSR_AW-1:0] RANGE_ADDR = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] SPARE_ADDR = CSR_AW'(4);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic [COORD_W-1:0]            range;
      logic [COUNT_W-1:0]            count;
      point_type [CAPACITY-1:0]      pts;
   } dedup_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  count;
   } dedup_result_type;

   logic clock;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   ppd_req_if hits_if ();
   ppd_rsp_if results_if ();

   proximity_point_deduplicator dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (hits_if),
      .rsp_if      (results_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   point_type        pending_hits[$];
   dedup_result_type expected_results[$];
   dedup_state_type  table_model;
   dedup_state_type  plan_state;
   dedup_state_type  trial_state;
   dedup_result_type oldest;
   dedup_result_type accepted_result;
   dedup_result_type trial_result;
   point_type        next_hit;
   point_type        candidate;
   bit               hit_in_flight;
   int               idle_pct;
   int               errors;
   int               cycles;
   int               hits_accepted;
   int               range_settings;
   int               status_seen[3];

   function automatic dedup_result_type evaluate_hit(inout dedup_state_type st,
                                                     input point_type h);
      dedup_result_type r;
      bit near;
      int i, dx, dy;
      r = '0;
      near = 1'b0;
      if (st.count >= CAPACITY) begin
         r.status = ST_FULL;
      end else begin
         for (i = 0; i < CAPACITY; i++) begin
            dx = (st.pts[ADDR_W'(i)].x >= h.x) ? int'(st.pts[ADDR_W'(i)].x) - int'(h.x)
                                                : int'(h.x) - int'(st.pts[ADDR_W'(i)].x);
            dy = (st.pts[ADDR_W'(i)].y >= h.y) ? int'(st.pts[ADDR_W'(i)].y) - int'(h.y)
                                                : int'(h.y) - int'(st.pts[ADDR_W'(i)].y);
            if (i < st.count && dx < int'(st.range) && dy < int'(st.range))
               near = 1'b1;
         end
         if (near) begin
            r.status = ST_CLOSE;
         end else begin
            r.status = ST_STORED;
            r.slot = st.count;
            st.pts[ADDR_W'(st.count)] = h;
            st.count = st.count + 1'b1;
         end
      end
      r.count = st.count;
      return r;
   endfunction

   // coordinate at, just inside or just outside the range from c
   function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
      int d, v;
      case ($urandom_range(4))
         0: d = 0;
         1: d = int'(r) - 1;
         2: d = int'(r);
         3: d = int'(r) + 1;
         default: d = $urandom_range(int'(r) + 1);
      endcase
      if ($urandom_range(1)) d = -d;
      v = int'(c) + d;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[COORD_W-1:0];
   endfunction

   function automatic point_type plan_hit(dedup_state_type st);
      point_type h;
      point_type p;
      if (st.count == 0 || st.count >= CAPACITY || $urandom_range(99) < 25) begin
         h.x = COORD_W'($urandom);
         h.y = COORD_W'($urandom);
         if ($urandom_range(9) == 0) h.x = $urandom_range(1) ? '1 : '0;
         if ($urandom_range(9) == 0) h.y = $urandom_range(1) ? '1 : '0;
      end else begin
         p = st.pts[ADDR_W'($urandom_range(int'(st.count) - 1))];
         h.x = nudge(p.x, st.range);
         h.y = nudge(p.y, st.range);
      end
      return h;
   endfunction

   task automatic wait_drain();
      while (pending_hits.size() != 0 || hit_in_flight || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == RANGE_ADDR) begin
         table_model.range = data[COORD_W-1:0];
         range_settings++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_range_readback();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= RANGE_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DW'(table_model.range)) begin
         $error("proximity_range expected %0d actual %0d", table_model.range, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_hit(input int x, input int y);
      point_type h;
      h.x = x[COORD_W-1:0];
      h.y = y[COORD_W-1:0];
      pending_hits.push_back(h);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hit driver
   always @(negedge clock) begin
      if (reset) begin
         hits_if.valid <= 1'b0;
      end else if (!hit_in_flight) begin
         if (pending_hits.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_hit = pending_hits.pop_front();
            hits_if.valid <= 1'b1;
            hits_if.hit_x <= next_hit.x;
            hits_if.hit_y <= next_hit.y;
            hit_in_flight = 1'b1;
         end else begin
            hits_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && hits_if.valid && hits_if.ready) begin
         accepted_result = evaluate_hit(table_model, {hits_if.hit_x, hits_if.hit_y});
         expected_results.push_back(accepted_result);
         hit_in_flight = 1'b0;
         hits_accepted++;
      end
   end

   always @(negedge clock) begin
      results_if.ready <= reset ? 1'b1 : ($urandom_range(99) >= idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("proximity_point_deduplicator_tb NOT OK");
         $finish;
      end else if (!reset && results_if.valid && results_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no hit outstanding, status %0d", results_if.status);
            errors++;
         end else begin
            oldest = expected_results.pop_front();
            if (oldest.status <= ST_FULL) status_seen[oldest.status]++;
            if (results_if.status !== oldest.status) begin
               $error("status expected %0d actual %0d", oldest.status, results_if.status);
               errors++;
            end
            if (results_if.slot !== oldest.slot) begin
               $error("slot expected %0d actual %0d", oldest.slot, results_if.slot);
               errors++;
            end
            if (results_if.point_count !== oldest.count) begin
               $error("point_count expected %0d actual %0d", oldest.count,
                      results_if.point_count);
               errors++;
            end
         end
      end
   end

   initial begin
      int phase, n, tries, target, dir_count;
      bit allow_store;
      logic [COORD_W-1:0] new_range;

      reset = 1'b1;
      hits_if.valid = 1'b0;
      hits_if.hit_x = '0;
      hits_if.hit_y = '0;
      results_if.ready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hit_in_flight = 1'b0;
      idle_pct = 8;
      errors = 0;
      cycles = 0;
      hits_accepted = 0;
      range_settings = 1;
      status_seen = '{0, 0, 0};
      table_model = '0;
      table_model.range = RANGE_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset range, axis boundaries, extremes, ignored register index
      check_range_readback();
      send_hit(0, 0);
      send_hit(0, 0);
      send_hit(49, 49);
      send_hit(50, 0);
      send_hit(0, 50);
      send_hit(65535, 65535);
      send_hit(65535 - 49, 65535);
      wait_drain();
      write_csr(SPARE_ADDR, 32'd0);
      check_range_readback();
      send_hit(25, 25);
      wait_drain();
      write_csr(RANGE_ADDR, 32'hFFFF);
      send_hit(32768, 32768);
      send_hit(65535, 0);
      wait_drain();
      // zero range stores every hit
      write_csr(RANGE_ADDR, 32'h0);
      send_hit(0, 0);
      send_hit(0, 0);
      wait_drain();
      write_csr(RANGE_ADDR, 32'h1);
      send_hit(0, 0);
      send_hit(1, 1);
      send_hit(16'hAAAA, 16'h5555);
      send_hit(16'h5555, 16'hAAAA);
      wait_drain();
      dir_count = int'(table_model.count);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drain();
         idle_pct = (phase >= 8 && phase < 13) ? 0 : 8;
         case ($urandom_range(6))
            0: new_range = COORD_W'(1);
            1: new_range = COORD_W'(2);
            2: new_range = COORD_W'(50);
            3: new_range = COORD_W'(1000);
            4: new_range = 16'hFFFF;
            5: new_range = COORD_W'($urandom_range(300));
            default: new_range = COORD_W'($urandom);
         endcase
         if (table_model.count >= CAPACITY && $urandom_range(3) == 0) new_range = '0;
         write_csr(RANGE_ADDR, {16'($urandom), new_range});
         if (phase % 4 == 0) begin
            write_csr(SPARE_ADDR, $urandom);
            check_range_readback();
         end
         target = dir_count + ((CAPACITY - dir_count) * (phase + 1)) / FILL_PHASES;
         if (target > CAPACITY) target = CAPACITY;
         plan_state = table_model;
         for (n = 0; n < PHASE_HITS; n++) begin
            allow_store = plan_state.count < target;
            for (tries = 0; tries < 8; tries++) begin
               candidate = plan_hit(plan_state);
               trial_state = plan_state;
               trial_result = evaluate_hit(trial_state, candidate);
               if (allow_store || trial_result.status != ST_STORED) break;
            end
            if (!allow_store && trial_result.status == ST_STORED && plan_state.count != 0)
               candidate = plan_state.pts[ADDR_W'($urandom_range(int'(plan_state.count) - 1))];
            trial_result = evaluate_hit(plan_state, candidate);
            pending_hits.push_back(candidate);
         end
      end

      wait_drain();
      repeat (SETTLE) @(posedge clock);
      $display("%0d hits over %0d range settings, table filled to %0d of %0d",
               hits_accepted, range_settings, table_model.count, CAPACITY);
      $display("results: %0d stored, %0d too close, %0d on a full table",
               status_seen[0], status_seen[1], status_seen[2]);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("proximity_point_deduplicator_tb OK");
      end else begin
         $display("proximity_point_deduplicator_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ppd_pkg.sv
sv/ppd_if.sv
sv/ppd_ram.sv
sv/proximity_point_deduplicator.sv
sv/ppd_checker.sv
tb/sv/proximity_point_deduplicator_tb.sv
